>>> hw/rtl/cts_pkg.sv
package cts_pkg;

  // Field and register widths
  localparam int ANGLE_W   = 16;
  localparam int COS_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 8;

  // Series length and the term counter
  localparam int MAX_TERMS = 16;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = $clog2(MAX_TERMS);

  // Fixed-point formats
  localparam int ANGLE_FRAC       = 6;
  localparam int WORK_FRAC        = 20;
  localparam int RESULT_FRAC_BITS = 16;
  localparam int RAD_SHIFT        = 32 + ANGLE_FRAC - WORK_FRAC;
  localparam int DOWN_SHIFT       = WORK_FRAC - RESULT_FRAC_BITS;

  // Datapath widths. For any 16-bit angle the radian value stays below 2^24,
  // its square below 2^27, and the series numerator below 2^37.
  localparam int X_W    = 24;
  localparam int X2_W   = 27;
  localparam int TERM_W = 37;
  localparam int SUM_W  = 42;
  localparam int MAG_W  = SUM_W - DOWN_SHIFT;
  localparam int PROD_W = TERM_W + X2_W;
  localparam int DIV_W  = 10;

  // Reciprocals of the term divisors, scaled by 2^RECIP_W, split in two
  // halves so that each half fits the shared multiplier.
  localparam int RECIP_W    = TERM_W;
  localparam int RECIP_LO_W = X2_W;
  localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
  localparam int QSUM_W     = TERM_W + RECIP_W;

  // pi/180 in unsigned Q0.32 with pi taken as 3.14159
  localparam logic [X2_W-1:0] RAD_PER_DEG =
    X2_W'(((64'd314159 << 32) + 64'd9000000) / 64'd18000000);

  localparam logic [TERM_W-1:0] ONE_WORK = TERM_W'(64'd1 << WORK_FRAC);
  localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(64'd1 << 36);
  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_W;

  // Divisor 2i(2i-1) of term i, stored at index i-1
  localparam logic [DIV_W-1:0] DIVISOR [MAX_TERMS] = '{
    10'd2,   10'd12,  10'd30,  10'd56,  10'd90,  10'd132, 10'd182, 10'd240,
    10'd306, 10'd380, 10'd462, 10'd552, 10'd650, 10'd756, 10'd870, 10'd992
  };

  localparam logic [RECIP_W-1:0] RECIP [MAX_TERMS] = '{
    RECIP_W'(RECIP_ONE / 64'd2),   RECIP_W'(RECIP_ONE / 64'd12),
    RECIP_W'(RECIP_ONE / 64'd30),  RECIP_W'(RECIP_ONE / 64'd56),
    RECIP_W'(RECIP_ONE / 64'd90),  RECIP_W'(RECIP_ONE / 64'd132),
    RECIP_W'(RECIP_ONE / 64'd182), RECIP_W'(RECIP_ONE / 64'd240),
    RECIP_W'(RECIP_ONE / 64'd306), RECIP_W'(RECIP_ONE / 64'd380),
    RECIP_W'(RECIP_ONE / 64'd462), RECIP_W'(RECIP_ONE / 64'd552),
    RECIP_W'(RECIP_ONE / 64'd650), RECIP_W'(RECIP_ONE / 64'd756),
    RECIP_W'(RECIP_ONE / 64'd870), RECIP_W'(RECIP_ONE / 64'd992)
  };

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_ANGLE,
    OP_RAD,
    OP_MUL_SQ,
    OP_SQ,
    OP_MUL_TERM,
    OP_NUMER,
    OP_MUL_RLO,
    OP_MUL_RHI,
    OP_QUOT,
    OP_MUL_CHECK,
    OP_FIX,
    OP_ROUND,
    OP_SAT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             add_term;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

>>> hw/rtl/cosine_taylor_series.sv
// Channel  Direction  Signals                           Payload
// cfg      in         cfg_valid, cfg_ready, cfg_data    term_count [4:0]
// s        in         s_tvalid, s_tready, s_tdata       angle_deg [15:0]
// m        out        m_tvalid, m_tready, m_tdata,      cos_value [31:0],
//                     m_tuser                           overflow [0]
//
// Each item runs from its accept through the angle and square steps, then the
// steps of each term (N = terms used, 0 to 16; the accumulate step is skipped
// when N is zero), then goes idle. As the single 37x27 multiplier is shared,
// each term needs four passes through it and three rounding or fix-up steps.
// Reset loads term_count with 8 and leaves the block idle with no result.
// A result waits in the output register while the next item is computed;
// the block stalls only when a second result is ready before the first leaves.
module cosine_taylor_series (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cts_pkg::CFG_W-1:0]   cfg_data,   // term_count
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [cts_pkg::ANGLE_W-1:0] s_tdata,    // angle_deg
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cts_pkg::COS_W-1:0]   m_tdata,    // cos_value
  output logic [0:0]                  m_tuser     // overflow
);
  import cts_pkg::*;

  logic [CFG_W-1:0] term_count;
  cmd_t             ctrl_cmd;
  logic             ovf_flag;

  // Term count register. An item uses the count latched at its accept, so a
  // write is taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= CFG_W'(CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      term_count <= cfg_data;
    end
  end

  cts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .term_count (term_count),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cmd        (ctrl_cmd)
  );

  cts_datapath u_datapath (
    .clk       (clk),
    .cmd       (ctrl_cmd),
    .angle_deg (s_tdata),
    .cos_value (m_tdata),
    .overflow  (ovf_flag)
  );

  assign m_tuser = ovf_flag;

  // An accepted item keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after an item was accepted");

  // A new result only appears while the block is busy with an item.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result raised without an item in progress");

  // The output register is never overwritten while a result waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctrl_cmd.op == OP_SAT) |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

endmodule

>>> hw/rtl/cts_ctrl.sv
module cts_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cts_pkg::CFG_W-1:0] term_count,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output cts_pkg::cmd_t             cmd
);
  import cts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_ANGLE,
    S_RAD,
    S_MUL_SQ,
    S_SQ,
    S_MUL_TERM,
    S_NUMER,
    S_MUL_RLO,
    S_MUL_RHI,
    S_QUOT,
    S_MUL_CHECK,
    S_FIX,
    S_ACC,
    S_ROUND,
    S_SAT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] n_lim;
  logic [CNT_W-1:0] cnt_inc;
  logic             out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign cnt_inc  = CNT_W'(cnt + CNT_W'(1));

  // Decode the datapath operation for the current step.
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.add_term = 1'b0;
    cmd.idx      = cnt[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_MUL_ANGLE: cmd.op = OP_MUL_ANGLE;
      S_RAD:       cmd.op = OP_RAD;
      S_MUL_SQ:    cmd.op = OP_MUL_SQ;
      S_SQ:        cmd.op = OP_SQ;
      S_MUL_TERM: begin
        cmd.op       = OP_MUL_TERM;
        cmd.add_term = (cnt != '0);
      end
      S_NUMER:     cmd.op = OP_NUMER;
      S_MUL_RLO:   cmd.op = OP_MUL_RLO;
      S_MUL_RHI:   cmd.op = OP_MUL_RHI;
      S_QUOT:      cmd.op = OP_QUOT;
      S_MUL_CHECK: cmd.op = OP_MUL_CHECK;
      S_FIX:       cmd.op = OP_FIX;
      S_ACC:       cmd.add_term = 1'b1;
      S_ROUND:     cmd.op = OP_ROUND;
      S_SAT: begin
        if (out_free) begin
          cmd.op = OP_SAT;
        end
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

  // Step sequencer, term counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      n_lim    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The valid flag rises when a result is stored and falls when it is taken.
      if ((state == S_SAT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cnt   <= '0;
            n_lim <= (term_count > CFG_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                       : CNT_W'(term_count);
            state <= S_MUL_ANGLE;
          end
        end
        S_MUL_ANGLE: state <= S_RAD;
        S_RAD:       state <= S_MUL_SQ;
        S_MUL_SQ:    state <= S_SQ;
        S_SQ: begin
          state <= (n_lim == '0) ? S_ROUND : S_MUL_TERM;
        end
        S_MUL_TERM:  state <= S_NUMER;
        S_NUMER:     state <= S_MUL_RLO;
        S_MUL_RLO:   state <= S_MUL_RHI;
        S_MUL_RHI:   state <= S_QUOT;
        S_QUOT:      state <= S_MUL_CHECK;
        S_MUL_CHECK: state <= S_FIX;
        S_FIX: begin
          cnt   <= cnt_inc;
          state <= (cnt_inc == n_lim) ? S_ACC : S_MUL_TERM;
        end
        S_ACC:       state <= S_ROUND;
        S_ROUND:     state <= S_SAT;
        S_SAT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/cts_datapath.sv
module cts_datapath (
  input  logic                        clk,
  input  cts_pkg::cmd_t               cmd,
  input  logic [cts_pkg::ANGLE_W-1:0] angle_deg,
  output logic [cts_pkg::COS_W-1:0]   cos_value,
  output logic                        overflow
);
  import cts_pkg::*;

  logic [ANGLE_W-1:0]      am;
  logic [X_W-1:0]          xm;
  logic [X2_W-1:0]         x2;
  logic [TERM_W-1:0]       tm;
  logic                    tneg;
  logic [TERM_W-1:0]       nreg;
  logic [TERM_W-1:0]       q0;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       acc_lo;
  logic signed [SUM_W-1:0] sum;
  logic                    ovf;
  logic                    neg_r;
  logic [MAG_W-1:0]        mag;

  logic [TERM_W-1:0]  mul_a;
  logic [X2_W-1:0]    mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [RECIP_W-1:0] recip;
  logic [DIV_W-1:0]   div;

  logic [PROD_W-1:0]       rad_rnd;
  logic [PROD_W:0]         work_rnd;
  logic [QSUM_W-1:0]       quot_sum;
  logic [PROD_W:0]         chk_rhs;
  logic                    fix_up;
  logic [TERM_W-1:0]       q_fix;
  logic signed [SUM_W-1:0] term_ext;
  logic [SUM_W-1:0]        sum_u;
  logic [SUM_W-1:0]        rnd_sum;
  logic [MAG_W-1:0]        lim;
  logic                    sat;
  logic [COS_W-1:0]        mag_out;

  assign recip = RECIP[cmd.idx];
  assign div   = DIVISOR[cmd.idx];

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_ANGLE: begin
        mul_a = TERM_W'(am);
        mul_b = RAD_PER_DEG;
      end
      OP_MUL_SQ: begin
        mul_a = TERM_W'(xm);
        mul_b = X2_W'(xm);
      end
      OP_MUL_TERM: begin
        mul_a = tm;
        mul_b = x2;
      end
      OP_MUL_RLO: begin
        mul_a = nreg;
        mul_b = recip[RECIP_LO_W-1:0];
      end
      OP_MUL_RHI: begin
        mul_a = nreg;
        mul_b = X2_W'(recip[RECIP_W-1:RECIP_LO_W]);
      end
      OP_MUL_CHECK: begin
        mul_a = q0;
        mul_b = X2_W'(div);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding of products back to the working format, half away from zero.
  assign rad_rnd  = prod + (PROD_W'(1) << (RAD_SHIFT - 1));
  assign work_rnd = {1'b0, prod} + ((PROD_W + 1)'(1) << (WORK_FRAC - 1));

  // Quotient estimate from the two reciprocal partial products.
  assign quot_sum = {(QSUM_W - PROD_W)'(0), acc_lo}
                  + {prod[TERM_W+RECIP_HI_W-1:0], RECIP_LO_W'(0)};

  // The estimate is exact or one low; the remainder check fixes it.
  assign chk_rhs = {1'b0, prod} + (PROD_W + 1)'(div);
  assign fix_up  = ((PROD_W + 1)'(nreg) >= chk_rhs);
  assign q_fix   = q0 + TERM_W'(fix_up);

  assign term_ext = $signed(SUM_W'(tm));

  // Magnitude of the sum rounded to the result format.
  assign sum_u   = sum;
  assign rnd_sum = sum[SUM_W-1]
                 ? (~sum_u + SUM_W'((1 << (DOWN_SHIFT - 1)) + 1))
                 : (sum_u + SUM_W'(1 << (DOWN_SHIFT - 1)));

  // Saturation limits for a 32-bit signed result.
  assign lim     = neg_r ? MAG_W'(64'h8000_0000) : MAG_W'(64'h7FFF_FFFF);
  assign sat     = (mag > lim);
  assign mag_out = sat ? COS_W'(lim) : COS_W'(mag);

  // Working registers, updated by the operation of each step.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.add_term) begin
      sum <= tneg ? (sum - term_ext) : (sum + term_ext);
    end
    case (cmd.op)
      OP_LOAD: begin
        am   <= angle_deg[ANGLE_W-1] ? (~angle_deg + ANGLE_W'(1)) : angle_deg;
        tm   <= ONE_WORK;
        sum  <= $signed(SUM_W'(ONE_WORK));
        tneg <= 1'b0;
        ovf  <= 1'b0;
      end
      OP_RAD:     xm <= rad_rnd[RAD_SHIFT +: X_W];
      OP_SQ:      x2 <= work_rnd[WORK_FRAC +: X2_W];
      OP_NUMER: begin
        nreg <= work_rnd[WORK_FRAC +: TERM_W] + TERM_W'(div[DIV_W-1:1]);
      end
      OP_MUL_RHI: acc_lo <= prod;
      OP_QUOT:    q0 <= quot_sum[QSUM_W-1 -: TERM_W];
      OP_FIX: begin
        tneg <= ~tneg;
        if (q_fix > TERM_CAP) begin
          tm  <= TERM_CAP;
          ovf <= 1'b1;
        end else begin
          tm <= q_fix;
        end
      end
      OP_ROUND: begin
        neg_r <= sum[SUM_W-1];
        mag   <= rnd_sum[SUM_W-1:DOWN_SHIFT];
      end
      OP_SAT: begin
        cos_value <= neg_r ? (~mag_out + COS_W'(1)) : mag_out;
        overflow  <= ovf | sat;
      end
      default: begin
      end
    endcase
  end

endmodule
